// ===== hdl/crc8rfc_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the response frame checker.
`default_nettype none

package crc8rfc_pkg;

  // Longest frame accepted without the too-long flag, in bytes.
  localparam int MAX_FRAME = 128;
  // Byte counter holds 0 .. MAX_FRAME-1.
  localparam int IDX_W = $clog2(MAX_FRAME);
  // Frame length holds 1 .. MAX_FRAME.
  localparam int LEN_W = IDX_W + 1;

  localparam int BYTE_W = 8;
  localparam int COUNT_W = 7;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  // Address, command and CRC bytes around the payload.
  localparam int FRAME_OVERHEAD = 3;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h1C;
  localparam logic [BYTE_W-1:0] EXPECTED_COMMAND_RESET = 8'h01;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 8'd1;

  // Output tdata: payload_byte, frame_status, payload_count, zero pad.
  localparam int STATUS_W = 3;
  localparam int OUT_FIELDS_W = BYTE_W + STATUS_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_HEADER = 3'd2,
    ST_CRC    = 3'd3,
    ST_LONG   = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  payload_byte;
    logic               payload_valid;
    logic               frame_done;
    frame_status_t      frame_status;
    logic [COUNT_W-1:0] payload_count;
  } result_t;

  // One byte through CRC-8, poly 0x07, MSB first, no reflection.
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/crc8_response_frame_checker_unit.sv =====
// Top level of the CRC-8 response frame checker.
//
// Input stream (s_*): one received byte per transaction, s_tlast high on the
// final byte of a frame, which is the CRC-8 (poly 0x07, init 0) over all
// earlier bytes. Byte 0 must match device_address, byte 1 expected_command.
// Output stream (m_*): at most one transaction per input byte. A payload
// byte is forwarded one byte late (m_tuser high) while the header matched
// and the frame is within MAX_FRAME bytes; the final byte produces a
// transaction with m_tlast high, the frame status and the payload count.
// Each result is registered and is on m_* the cycle after its byte is taken.
// Throughput: one byte per cycle unless the receiver stalls; CRC is a single combinational byte update
// and the output register refills in the cycle its transaction completes.
// Receiver stall: s_tready drops only while the output register holds a
// result and m_tready is low.
// Reset (rst, synchronous): frame state cleared, registers back to
// address 0x1C and command 0x01, output empty.
// Config writes (cfg_*) are always taken; write only while idle.
`default_nettype none

module crc8_response_frame_checker_unit
  import crc8rfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  input  wire logic                 s_tlast,   // end_of_frame
  // Result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_DATA_W-1:0]     m_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                               // [17:11] payload_count, [23:18] zero
  output logic                      m_tuser,   // [0] payload_valid
  output logic                      m_tlast,   // frame_done
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] device_address;
  logic [BYTE_W-1:0] expected_command;

  logic    room;
  logic    accept;
  logic    has_result;
  result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= DEVICE_ADDRESS_RESET;
      expected_command <= EXPECTED_COMMAND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS:   device_address   <= cfg_data;
        REG_EXPECTED_COMMAND: expected_command <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // Take a byte whenever the output register can take its result.
  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  crc8rfc_frame_tracker u_tracker (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (s_tdata),
    .end_of_frame     (s_tlast),
    .device_address   (device_address),
    .expected_command (expected_command),
    .has_result       (has_result),
    .result           (result)
  );

  crc8rfc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && has_result),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Input is never stalled while the output holds nothing.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A final byte always yields a closing transaction next cycle.
  a_eof_closes: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid && m_tlast)
    else $error("final byte produced no closing transaction");

  // Pad bits above the packed fields stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
    else $error("nonzero pad in result data");

endmodule

`default_nettype wire

// ===== hdl/crc8rfc_frame_tracker.sv =====
// Per-frame state: header check, running CRC, byte count and one-byte payload delay.
`default_nettype none

module crc8rfc_frame_tracker
  import crc8rfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic              end_of_frame,
  input  wire logic [BYTE_W-1:0] device_address,
  input  wire logic [BYTE_W-1:0] expected_command,
  output logic                   has_result,
  output result_t                result
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FRAME - 1);

  logic [BYTE_W-1:0] running_crc, running_crc_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic              header_good, header_good_next;
  logic              overflowed, overflowed_next;

  logic              fwd;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  diff;
  logic              len_ok;

  always_comb begin
    fwd    = (byte_index >= IDX_W'(FRAME_OVERHEAD)) && header_good && !overflowed;
    len    = {1'b0, byte_index} + LEN_W'(1);
    len_ok = len >= LEN_W'(FRAME_OVERHEAD);
    diff   = len - LEN_W'(FRAME_OVERHEAD);

    result.payload_byte  = fwd ? held_byte : '0;
    result.payload_valid = fwd;
    result.frame_done    = end_of_frame;
    result.frame_status  = ST_OK;
    result.payload_count = '0;
    if (end_of_frame) begin
      if (overflowed)                result.frame_status = ST_LONG;
      else if (!len_ok)              result.frame_status = ST_SHORT;
      else if (!header_good)         result.frame_status = ST_HEADER;
      else if (rx_byte != running_crc) result.frame_status = ST_CRC;
      if (!overflowed && len_ok) begin
        if (32'(diff) > 32'(COUNT_MAX)) result.payload_count = COUNT_W'(COUNT_MAX);
        else                            result.payload_count = COUNT_W'(diff);
      end
    end
    has_result = end_of_frame || fwd;

    running_crc_next = running_crc;
    byte_index_next  = byte_index;
    held_byte_next   = held_byte;
    header_good_next = header_good;
    overflowed_next  = overflowed;
    if (accept) begin
      if (end_of_frame) begin
        running_crc_next = '0;
        byte_index_next  = '0;
        held_byte_next   = '0;
        header_good_next = 1'b1;
        overflowed_next  = 1'b0;
      end else begin
        if (byte_index == IDX_W'(0) && rx_byte != device_address)   header_good_next = 1'b0;
        if (byte_index == IDX_W'(1) && rx_byte != expected_command) header_good_next = 1'b0;
        running_crc_next = crc8_update(running_crc, rx_byte);
        held_byte_next   = rx_byte;
        if (byte_index >= IDX_LAST) overflowed_next = 1'b1;
        else                        byte_index_next = byte_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      byte_index  <= '0;
      held_byte   <= '0;
      header_good <= 1'b1;
      overflowed  <= 1'b0;
    end else begin
      running_crc <= running_crc_next;
      byte_index  <= byte_index_next;
      held_byte   <= held_byte_next;
      header_good <= header_good_next;
      overflowed  <= overflowed_next;
    end
  end

  // A closed frame leaves the tracker in its reset state.
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_frame |=> byte_index == '0 && running_crc == '0
                               && header_good && !overflowed)
    else $error("frame state not cleared after final byte");

  // Overflow only happens with the counter parked at its top.
  a_overflow_saturates: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> byte_index == IDX_LAST)
    else $error("overflow flag set below byte bound");

  // Status and count are zero outside the closing result.
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    !result.frame_done |-> result.frame_status == ST_OK && result.payload_count == '0)
    else $error("status or count nonzero outside frame end");

endmodule

`default_nettype wire

// ===== hdl/crc8rfc_out_stage.sv =====
// Output register between the tracker and the result stream.
`default_nettype none

module crc8rfc_out_stage
  import crc8rfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire result_t               result,
  output logic                       room,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  result_t held;
  logic    valid;

  // Register frees up in the same cycle its transaction completes.
  assign room = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      held <= result;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = OUT_DATA_W'({held.payload_count, held.frame_status, held.payload_byte});
  assign m_tuser  = held.payload_valid;
  assign m_tlast  = held.frame_done;

  a_empty_has_room: assert property (@(posedge clk) disable iff (rst)
    !valid |-> room)
    else $error("empty output register refuses data");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    room && load |=> valid)
    else $error("loaded result not presented");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    valid && m_tready && !load |=> !valid)
    else $error("taken result presented again");

endmodule

`default_nettype wire
